FILE: sv/nfr_pkg.sv
// shared types and constants for the numeric format recognizer
// character classes, scanner phases, queue entry and result layout; no dependencies
package nfr_pkg;

    localparam int NFR_MAX_LEN   = 4096;
    localparam int NFR_POS_CAP   = 4096;
    localparam int NFR_QDEPTH    = 2;
    localparam int NFR_CH_W      = 8;
    localparam int NFR_END_W     = 12;
    localparam int NFR_CFG_IDX_W = 8;
    localparam int NFR_CFG_W     = 64;
    localparam int NFR_NUM_DELIM = 4;
    localparam int NFR_OUT_W     = 32;

    // character codes the scanners care about
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_E = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;

    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_SPACE,
        CLS_SIGN,
        CLS_DIGIT,
        CLS_DOT,
        CLS_EXP,
        CLS_NUL
    } t_cls;

    typedef struct packed {
        t_cls cls;
        logic delim;
    } t_item;

    typedef enum logic [2:0] {
        IP_WS,
        IP_SIGN,
        IP_DIG,
        IP_DONE,
        IP_FAIL
    } t_int_phase;

    typedef enum logic [3:0] {
        FP_WS,
        FP_SIGN,
        FP_IDIG,
        FP_DOT0,
        FP_FDIG,
        FP_EWS,
        FP_ESIGN,
        FP_EDIG,
        FP_DONE,
        FP_FAIL
    } t_flt_phase;

    typedef struct packed {
        logic                 too_long;
        logic [NFR_END_W-1:0] flt_end;
        logic                 flt_delim;
        logic                 flt_exact;
        logic [NFR_END_W-1:0] int_end;
        logic                 int_delim;
        logic                 int_exact;
    } t_result;

    function automatic t_cls classify(input logic [7:0] c);
        t_cls k;
        if (c == CH_NUL) begin
            k = CLS_NUL;
        end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            k = CLS_SPACE;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            k = CLS_SIGN;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            k = CLS_DIGIT;
        end else if (c == CH_DOT) begin
            k = CLS_DOT;
        end else if (c == CH_LOW_E || c == CH_UP_E) begin
            k = CLS_EXP;
        end else begin
            k = CLS_OTHER;
        end
        return k;
    endfunction

endpackage

FILE: sv/nfr_front.sv
// front end: holds the delimiter set and classifies each incoming character
// depends on nfr_pkg
module nfr_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [nfr_pkg::NFR_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nfr_pkg::NFR_CFG_W-1:0]  i_cfg_data,
    input  logic [nfr_pkg::NFR_CH_W-1:0]   i_ch,
    output nfr_pkg::t_item                 o_item
);
    import nfr_pkg::*;

    logic [NFR_CFG_W-1:0] r_delim [NFR_NUM_DELIM];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NFR_NUM_DELIM; k++) begin
                r_delim[k] <= '0;
            end
        end else if (i_cfg_valid && i_cfg_index < NFR_CFG_IDX_W'(NFR_NUM_DELIM)) begin
            r_delim[i_cfg_index[1:0]] <= i_cfg_data;
        end
    end

    // nul always counts as a delimiter
    always_comb begin
        o_item.cls   = classify(i_ch);
        o_item.delim = (i_ch == CH_NUL) | r_delim[i_ch[7:6]][i_ch[5:0]];
    end

endmodule

FILE: sv/nfr_queue.sv
// short queue of classified characters between front and back
// depends on nfr_pkg
module nfr_queue #(
    parameter int DEPTH = nfr_pkg::NFR_QDEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  nfr_pkg::t_item i_item,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output nfr_pkg::t_item o_item
);
    import nfr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: sv/nfr_back.sv
// back end: integer and float scanners, position counter and result register
// depends on nfr_pkg
module nfr_back #(
    parameter int LEN_LIMIT = nfr_pkg::NFR_POS_CAP
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  nfr_pkg::t_item  i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output nfr_pkg::t_result o_result
);
    import nfr_pkg::*;

    localparam int POS_W = $clog2(LEN_LIMIT);

    t_int_phase       r_ip, n_ip;
    t_flt_phase       r_fp, n_fp;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_istop, n_istop;
    logic [POS_W-1:0] r_fstop, n_fstop;
    logic             r_iverd, n_iverd;
    logic             r_fverd, n_fverd;
    logic             r_ovf;
    logic             r_out_valid;
    t_result          r_out;
    t_result          n_out;
    logic             w_nul;
    logic             w_digit;

    assign w_nul   = (i_item.cls == CLS_NUL);
    assign w_digit = (i_item.cls == CLS_DIGIT);
    // a nul waits only for room in the result register
    assign o_pop   = i_valid && (!w_nul || !r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_ip    = r_ip;
        n_istop = r_istop;
        n_iverd = r_iverd;
        case (r_ip)
            IP_WS: begin
                if (i_item.cls == CLS_SPACE) begin
                    n_ip = IP_WS;
                end else if (i_item.cls == CLS_SIGN) begin
                    n_ip = IP_SIGN;
                end else if (w_digit) begin
                    n_ip = IP_DIG;
                end else begin
                    n_ip = IP_FAIL;
                end
            end
            IP_SIGN: begin
                n_ip = w_digit ? IP_DIG : IP_FAIL;
            end
            IP_DIG: begin
                if (!w_digit) begin
                    n_ip    = IP_DONE;
                    n_istop = r_pos;
                    n_iverd = i_item.delim;
                end
            end
            default: begin
                n_ip = r_ip;
            end
        endcase
    end

    always_comb begin
        n_fp    = r_fp;
        n_fstop = r_fstop;
        n_fverd = r_fverd;
        case (r_fp)
            FP_WS, FP_SIGN: begin
                if (r_fp == FP_WS && i_item.cls == CLS_SPACE) begin
                    n_fp = FP_WS;
                end else if (r_fp == FP_WS && i_item.cls == CLS_SIGN) begin
                    n_fp = FP_SIGN;
                end else if (w_digit) begin
                    n_fp = FP_IDIG;
                end else if (i_item.cls == CLS_DOT) begin
                    n_fp = FP_DOT0;
                end else begin
                    n_fp = FP_FAIL;
                end
            end
            FP_IDIG: begin
                if (w_digit) begin
                    n_fp = FP_IDIG;
                end else if (i_item.cls == CLS_DOT) begin
                    n_fp = FP_FDIG;
                end else if (i_item.cls == CLS_EXP) begin
                    n_fp = FP_EWS;
                end else begin
                    n_fp    = FP_DONE;
                    n_fstop = r_pos;
                    n_fverd = i_item.delim;
                end
            end
            FP_DOT0: begin
                n_fp = w_digit ? FP_FDIG : FP_FAIL;
            end
            FP_FDIG: begin
                if (w_digit) begin
                    n_fp = FP_FDIG;
                end else if (i_item.cls == CLS_EXP) begin
                    n_fp = FP_EWS;
                end else begin
                    n_fp    = FP_DONE;
                    n_fstop = r_pos;
                    n_fverd = i_item.delim;
                end
            end
            FP_EWS: begin
                if (i_item.cls == CLS_SPACE) begin
                    n_fp = FP_EWS;
                end else if (i_item.cls == CLS_SIGN) begin
                    n_fp = FP_ESIGN;
                end else if (w_digit) begin
                    n_fp = FP_EDIG;
                end else begin
                    n_fp = FP_FAIL;
                end
            end
            FP_ESIGN: begin
                n_fp = w_digit ? FP_EDIG : FP_FAIL;
            end
            FP_EDIG: begin
                if (!w_digit) begin
                    n_fp    = FP_DONE;
                    n_fstop = r_pos;
                    n_fverd = i_item.delim;
                end
            end
            default: begin
                n_fp = r_fp;
            end
        endcase
    end

    // result for a nul, taken from the state after the nul itself was scanned
    always_comb begin
        n_out = '0;
        if (r_ovf) begin
            n_out.too_long = 1'b1;
        end else begin
            if (n_ip == IP_DONE) begin
                n_out.int_exact = (n_istop == r_pos);
                n_out.int_delim = n_iverd;
                n_out.int_end   = NFR_END_W'(n_istop);
            end
            if (n_fp == FP_DONE) begin
                n_out.flt_exact = (n_fstop == r_pos);
                n_out.flt_delim = n_fverd;
                n_out.flt_end   = NFR_END_W'(n_fstop);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_nul) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip        <= IP_WS;
            r_fp        <= FP_WS;
            r_pos       <= '0;
            r_istop     <= '0;
            r_fstop     <= '0;
            r_iverd     <= 1'b0;
            r_fverd     <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && w_nul) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                if (w_nul) begin
                    r_ip    <= IP_WS;
                    r_fp    <= FP_WS;
                    r_pos   <= '0;
                    r_istop <= '0;
                    r_fstop <= '0;
                    r_iverd <= 1'b0;
                    r_fverd <= 1'b0;
                    r_ovf   <= 1'b0;
                end else if (!r_ovf) begin
                    if (r_pos == POS_W'(LEN_LIMIT - 1)) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_ip    <= n_ip;
                        r_fp    <= n_fp;
                        r_istop <= n_istop;
                        r_fstop <= n_fstop;
                        r_iverd <= n_iverd;
                        r_fverd <= n_fverd;
                        r_pos   <= r_pos + 1'b1;
                    end
                end
            end
        end
    end

endmodule

FILE: sv/numeric_format_recognizer.sv
// top level of the numeric format recognizer
// depends on nfr_pkg, nfr_front, nfr_queue, nfr_back
//
// Takes a NUL-terminated string one character per transaction and, at the NUL, returns
// one result saying whether the string is an integer and/or a float, exact or ending at a
// delimiter, with the stop offsets. Every character is classified on arrival (delimiter
// membership uses the set as it stands then) and written to a two-entry queue; the scanner
// stage takes one queued character per cycle unless it holds a NUL, so the block sustains
// one character per clock while the result stream is not stalled. A result is registered
// when the scanner stage pops its NUL from the queue; the scanner stage holds a NUL only
// while the result register is still full. Strings of LEN_LIMIT = min(MAX_LEN, 4096)
// characters or more report too_long with all other fields zero.
module numeric_format_recognizer #(
    parameter int MAX_LEN = nfr_pkg::NFR_MAX_LEN,
    parameter int QDEPTH  = nfr_pkg::NFR_QDEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [nfr_pkg::NFR_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nfr_pkg::NFR_CFG_W-1:0]     i_cfg_data,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [nfr_pkg::NFR_CH_W-1:0]      i_s_tdata,  // [7:0] ch
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [0] int_exact, [1] int_delim, [13:2] int_end, [14] flt_exact, [15] flt_delim,
    // [27:16] flt_end, [28] too_long, [31:29] zero
    output logic [nfr_pkg::NFR_OUT_W-1:0]     o_m_tdata
);
    import nfr_pkg::*;

    localparam int LEN_LIMIT = (MAX_LEN < NFR_POS_CAP) ? MAX_LEN : NFR_POS_CAP;

    t_item   w_front_item;
    t_item   w_q_item;
    logic    w_q_ready;
    logic    w_q_valid;
    logic    w_pop;
    t_result w_result;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = w_q_ready;
    assign o_m_tdata   = NFR_OUT_W'(w_result);

    nfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_ch        (i_s_tdata),
        .o_item      (w_front_item)
    );

    nfr_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_tvalid),
        .i_item  (w_front_item),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    nfr_back #(
        .LEN_LIMIT (LEN_LIMIT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_item   (w_q_item),
        .o_pop    (w_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (w_result)
    );

endmodule

FILE: sv/nfr_checker.sv
// port-level checks on the result stream of the numeric format recognizer
// depends on nfr_pkg; bound to numeric_format_recognizer
module nfr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [nfr_pkg::NFR_OUT_W-1:0] o_m_tdata
);
    import nfr_pkg::*;

    // a stalled transaction keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // too_long clears every scan field
    a_too_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[28] |-> o_m_tdata[27:0] == 28'd0)
        else $error("too_long result carries scan fields");

    // stopping at the nul means the match is also delimited
    a_int_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[0] |-> o_m_tdata[1])
        else $error("int exact without delim");

    a_flt_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[14] |-> o_m_tdata[15])
        else $error("float exact without delim");

    // a float scan needs a digit, so it never stops at offset zero
    a_flt_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[15] |-> o_m_tdata[27:16] != 12'd0)
        else $error("float delim match at offset zero");

endmodule

bind numeric_format_recognizer nfr_checker u_nfr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: tb/sv/tb_numeric_format_recognizer.sv
// self-checking testbench for numeric_format_recognizer
// depends on nfr_pkg and the rtl; predicts each result from the accepted characters
// and checks it field by field against the output stream under random stalls
module tb_numeric_format_recognizer;
    import nfr_pkg::*;

    localparam int LEN_LIMIT    = (NFR_MAX_LEN < 4096) ? NFR_MAX_LEN : 4096;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int STALL_CYCLES = 300;
    localparam int RANDOM_CHARS = 1850;
    localparam int NUM_PHASES   = 4;
    localparam int MAX_PRINTS   = 40;

    localparam logic [NFR_CFG_IDX_W-1:0] REG_DELIM_SET_0 = 0;
    localparam logic [NFR_CFG_IDX_W-1:0] REG_DELIM_SET_1 = 1;
    localparam logic [NFR_CFG_IDX_W-1:0] REG_DELIM_SET_2 = 2;
    localparam logic [NFR_CFG_IDX_W-1:0] REG_DELIM_SET_3 = 3;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic [NFR_CFG_IDX_W-1:0] cfg_index = '0;
    logic [NFR_CFG_W-1:0]     cfg_data = '0;
    logic                     s_valid = 1'b0;
    logic [NFR_CH_W-1:0]      s_data = '0;
    logic                     m_tready = 1'b0;
    logic                     o_cfg_ready;
    logic                     o_s_tready;
    logic                     o_m_tvalid;
    logic [NFR_OUT_W-1:0]     o_m_tdata;

    numeric_format_recognizer #(
        .MAX_LEN(NFR_MAX_LEN),
        .QDEPTH (NFR_QDEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #4 i_clk = ~i_clk;

    // scanner mirror
    logic [NFR_CFG_W-1:0] delim_mirror [NFR_NUM_DELIM];
    t_int_phase           int_scan = IP_WS;
    t_flt_phase           flt_scan = FP_WS;
    logic [NFR_END_W-1:0] scan_pos = '0;
    logic [NFR_END_W-1:0] int_stop_at = '0;
    logic [NFR_END_W-1:0] flt_stop_at = '0;
    logic                 int_at_delim = 1'b0;
    logic                 flt_at_delim = 1'b0;
    logic                 string_overflow = 1'b0;
    t_result              pending_results[$];

    logic [7:0] text[$];
    bit         src_burst = 1'b0;
    bit         sink_burst = 1'b0;
    int         sink_wait = 0;
    logic       stall_on = 1'b0;
    event       stall_go;
    int         errors = 0;
    int         chars_sent = 0;
    int         strings_sent = 0;
    int         results_seen = 0;
    int         cycle_count = 0;

    initial begin
        for (int k = 0; k < NFR_NUM_DELIM; k++) delim_mirror[k] = '0;
    end

    function automatic bit is_ws(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_sgn(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS;
    endfunction

    function automatic bit is_expo(input logic [7:0] c);
        return c == CH_LOW_E || c == CH_UP_E;
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        logic [NFR_CFG_W-1:0] set_word;
        set_word = delim_mirror[c[7:6]];
        return (c == CH_NUL) || set_word[c[5:0]];
    endfunction

    task automatic int_scan_char(input logic [7:0] c);
        case (int_scan)
            IP_WS: begin
                if (is_ws(c)) int_scan = IP_WS;
                else if (is_sgn(c)) int_scan = IP_SIGN;
                else if (is_num(c)) int_scan = IP_DIG;
                else int_scan = IP_FAIL;
            end
            IP_SIGN: int_scan = is_num(c) ? IP_DIG : IP_FAIL;
            IP_DIG: begin
                if (!is_num(c)) begin
                    int_scan = IP_DONE;
                    int_stop_at = scan_pos;
                    int_at_delim = is_delim(c);
                end
            end
            default: ;
        endcase
    endtask

    task automatic flt_finish(input logic [7:0] c);
        flt_scan = FP_DONE;
        flt_stop_at = scan_pos;
        flt_at_delim = is_delim(c);
    endtask

    task automatic flt_scan_char(input logic [7:0] c);
        case (flt_scan)
            FP_WS, FP_SIGN: begin
                if (flt_scan == FP_WS && is_ws(c)) flt_scan = FP_WS;
                else if (flt_scan == FP_WS && is_sgn(c)) flt_scan = FP_SIGN;
                else if (is_num(c)) flt_scan = FP_IDIG;
                else if (c == CH_DOT) flt_scan = FP_DOT0;
                else flt_scan = FP_FAIL;
            end
            FP_IDIG: begin
                if (is_num(c)) flt_scan = FP_IDIG;
                else if (c == CH_DOT) flt_scan = FP_FDIG;
                else if (is_expo(c)) flt_scan = FP_EWS;
                else flt_finish(c);
            end
            FP_DOT0: flt_scan = is_num(c) ? FP_FDIG : FP_FAIL;
            FP_FDIG: begin
                if (is_num(c)) flt_scan = FP_FDIG;
                else if (is_expo(c)) flt_scan = FP_EWS;
                else flt_finish(c);
            end
            // exponent accepts whitespace and a sign like a plain integer
            FP_EWS: begin
                if (is_ws(c)) flt_scan = FP_EWS;
                else if (is_sgn(c)) flt_scan = FP_ESIGN;
                else if (is_num(c)) flt_scan = FP_EDIG;
                else flt_scan = FP_FAIL;
            end
            FP_ESIGN: flt_scan = is_num(c) ? FP_EDIG : FP_FAIL;
            FP_EDIG: begin
                if (!is_num(c)) flt_finish(c);
            end
            default: ;
        endcase
    endtask

    task automatic predict_char(input logic [7:0] c);
        t_result r;
        if (c != CH_NUL) begin
            if (!string_overflow) begin
                if ({1'b0, scan_pos} + 13'd1 >= 13'(LEN_LIMIT)) begin
                    string_overflow = 1'b1;
                end else begin
                    int_scan_char(c);
                    flt_scan_char(c);
                    scan_pos = scan_pos + 1'b1;
                end
            end
        end else begin
            r = '0;
            if (string_overflow) begin
                r.too_long = 1'b1;
            end else begin
                // the nul acts as the stop character of a scan still running
                int_scan_char(c);
                flt_scan_char(c);
                if (int_scan == IP_DONE) begin
                    r.int_exact = (int_stop_at == scan_pos);
                    r.int_delim = int_at_delim;
                    r.int_end   = int_stop_at;
                end
                if (flt_scan == FP_DONE) begin
                    r.flt_exact = (flt_stop_at == scan_pos);
                    r.flt_delim = flt_at_delim;
                    r.flt_end   = flt_stop_at;
                end
            end
            pending_results.push_back(r);
            int_scan = IP_WS;
            flt_scan = FP_WS;
            scan_pos = '0;
            int_stop_at = '0;
            flt_stop_at = '0;
            int_at_delim = 1'b0;
            flt_at_delim = 1'b0;
            string_overflow = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch %s at cycle %0d: got %0d, expected %0d",
                     field, cycle_count, got, want);
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        results_seen++;
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", got, 0);
        end else begin
            want = pending_results.pop_front();
            if (got.int_exact !== want.int_exact)
                report_mismatch("int_exact", got.int_exact, want.int_exact);
            if (got.int_delim !== want.int_delim)
                report_mismatch("int_delim", got.int_delim, want.int_delim);
            if (got.int_end !== want.int_end)
                report_mismatch("int_end", got.int_end, want.int_end);
            if (got.flt_exact !== want.flt_exact)
                report_mismatch("flt_exact", got.flt_exact, want.flt_exact);
            if (got.flt_delim !== want.flt_delim)
                report_mismatch("flt_delim", got.flt_delim, want.flt_delim);
            if (got.flt_end !== want.flt_end)
                report_mismatch("flt_end", got.flt_end, want.flt_end);
            if (got.too_long !== want.too_long)
                report_mismatch("too_long", got.too_long, want.too_long);
        end
    endtask

    // result side: random per-transaction wait, plus a long hold when asked
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_tready) begin
            check_result(t_result'(o_m_tdata[$bits(t_result)-1:0]));
            sink_wait = sink_burst ? 0 : $urandom_range(0, 5);
            if ($urandom_range(0, 15) == 0) sink_burst = !sink_burst;
        end else if (sink_wait > 0) begin
            sink_wait--;
        end
        m_tready <= !stall_on && (sink_wait == 0);
    end

    always begin
        @(stall_go);
        stall_on <= 1'b1;
        repeat (STALL_CYCLES) @(posedge i_clk);
        stall_on <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge i_clk); while (!o_s_tready);
        chars_sent++;
        predict_char(c);
    endtask

    task automatic send_text(input bit fast);
        src_burst = fast || ($urandom_range(0, 3) == 0);
        foreach (text[k]) send_char(text[k]);
        send_char(CH_NUL);
        strings_sent++;
    endtask

    task automatic load_text(input string s);
        text.delete();
        for (int k = 0; k < s.len(); k++) text.push_back(s[k]);
    endtask

    task automatic add_digits(input int n);
        repeat (n) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic add_ws(input int n);
        repeat (n) text.push_back($urandom_range(0, 1) ? CH_SPACE :
                                  CH_TAB + 8'($urandom_range(0, 4)));
    endtask

    task automatic add_sign();
        text.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
    endtask

    // idle means no transaction in flight: source quiet and every result drained
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [NFR_CFG_IDX_W-1:0] idx,
                             input logic [NFR_CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < NFR_NUM_DELIM) delim_mirror[idx[1:0]] = val;
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_delims(input logic [NFR_CFG_W-1:0] d0, input logic [NFR_CFG_W-1:0] d1,
                                input logic [NFR_CFG_W-1:0] d2, input logic [NFR_CFG_W-1:0] d3);
        wait_idle();
        write_reg(REG_DELIM_SET_0, d0);
        write_reg(REG_DELIM_SET_1, d1);
        write_reg(REG_DELIM_SET_2, d2);
        write_reg(REG_DELIM_SET_3, d3);
        // indexes past the last set must leave the sets alone
        write_reg(NFR_CFG_IDX_W'($urandom_range(NFR_NUM_DELIM, 255)),
                  {$urandom, $urandom});
    endtask

    task automatic build_random_text();
        int n;
        text.delete();
        if ($urandom_range(0, 4) == 0) begin
            // noise: any non-nul code
            repeat ($urandom_range(0, 6)) text.push_back(8'($urandom_range(1, 255)));
        end else begin
            if ($urandom_range(0, 3) == 0) add_ws($urandom_range(1, 3));
            if ($urandom_range(0, 2) == 0) add_sign();
            add_digits($urandom_range(0, 4));
            if ($urandom_range(0, 2) == 0) begin
                text.push_back(CH_DOT);
                add_digits($urandom_range(0, 3));
            end
            if ($urandom_range(0, 2) == 0) begin
                text.push_back($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E);
                if ($urandom_range(0, 3) == 0) add_ws($urandom_range(1, 2));
                if ($urandom_range(0, 2) == 0) add_sign();
                add_digits($urandom_range(0, 3));
            end
            case ($urandom_range(0, 5))
                0: text.push_back(8'($urandom_range(1, 255)));
                1: text.push_back($urandom_range(0, 1) ? CH_SPACE : 8'h2c);
                2: begin
                    text.push_back(8'($urandom_range(1, 255)));
                    add_digits($urandom_range(1, 3));
                end
                default: ;
            endcase
            n = text.size();
            if (n > 0 && $urandom_range(0, 9) == 0)
                text[$urandom_range(0, n - 1)] = 8'($urandom_range(1, 255));
        end
    endtask

    task automatic test_directed();
        // delimiters: space and comma, 'x', and code 255
        write_delims(64'h0000_1001_0000_0000, 64'h0100_0000_0000_0000, '0,
                     64'h8000_0000_0000_0000);
        load_text("");        send_text(0);
        load_text("-9");      send_text(0);
        text.delete();
        text.push_back(CH_SPACE);
        text.push_back(CH_TAB);
        text.push_back(CH_PLUS);
        text.push_back(8'h37);
        send_text(0);
        load_text("1.5e+3");  send_text(0);
        load_text(".5");      send_text(0);
        load_text("7.");      send_text(0);
        load_text("1e");      send_text(0);
        load_text("2E 4");    send_text(0);
        load_text("3x");      send_text(0);
        load_text("-");       send_text(0);
        text.delete();
        for (int k = 10; k <= 13; k++) text.push_back(8'(k));
        text.push_back(8'h38);
        send_text(0);
        load_text("5");
        text.push_back(8'hff);
        send_text(0);
        text.delete();
        text.push_back(8'h01);
        text.push_back(8'h80);
        send_text(0);
    endtask

    task automatic test_too_long();
        // one under the limit, at the limit, and well past it
        int lens[3];
        lens[0] = LEN_LIMIT - 1;
        lens[1] = LEN_LIMIT;
        lens[2] = LEN_LIMIT + 20;
        for (int k = 0; k < 3; k++) begin
            text.delete();
            add_digits(lens[k]);
            send_text(1);
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        ->stall_go;
        // short strings of at most two digits make many results, so the block fills up
        repeat (40) begin
            text.delete();
            add_digits($urandom_range(0, 2));
            send_text(1);
        end
    endtask

    task automatic test_random_phases();
        int stop_at;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: write_delims('0, '0, '0, '0);
                1: write_delims('1, '1, '1, '1);
                2: write_delims({$urandom, $urandom}, {$urandom, $urandom},
                                {$urandom, $urandom}, {$urandom, $urandom});
                default: write_delims(64'h0800_1203_0000_3e00, 64'h0100_0000_2000_0000,
                                      {$urandom, $urandom}, {$urandom, $urandom});
            endcase
            stop_at = chars_sent + RANDOM_CHARS / NUM_PHASES;
            while (chars_sent < stop_at) begin
                build_random_text();
                send_text(0);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_too_long();
        test_backpressure();
        test_random_phases();
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("results never returned", 0, pending_results.size());
        $display("covered %0d strings (%0d characters) and %0d results across four delimiter",
                 strings_sent, chars_sent, results_seen);
        $display("settings, over-length strings and a %0d-cycle output stall", STALL_CYCLES);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
